[design/tsd_pkg.sv]
// Package for the temperature scratchpad decoder.
// Holds field widths, formula constants, state codes and the CRC-8 bit step.
// No dependencies.
package tsd_pkg;

   localparam int BYTE_W = 8;
   localparam int TEMP_W = 16;
   localparam int IDX_W  = 4;
   localparam int NUM_W  = 24;
   localparam int MAG_W  = 23;
   localparam int REM_W  = 5;
   localparam int CNT_W  = 5;
   localparam int ST_W   = 3;

   localparam logic [IDX_W-1:0]  SCRATCH_LAST = 4'd8;
   localparam logic [IDX_W-1:0]  IDX_READ_LO  = 4'd0;
   localparam logic [IDX_W-1:0]  IDX_READ_HI  = 4'd1;
   localparam logic [IDX_W-1:0]  IDX_COUNT    = 4'd6;
   localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h8C;

   localparam logic [REM_W:0]          DIVISOR  = 6'd20;
   localparam logic signed [NUM_W-1:0] OFFSET   = 24'sd25;
   localparam logic signed [9:0]       BIAS     = 10'sd16;
   localparam logic [MAG_W-1:0]        POS_MAX  = 23'd32767;
   localparam logic [MAG_W-1:0]        NEG_MAX  = 23'd32768;
   localparam logic [TEMP_W-1:0]       SAT_POS  = 16'h7FFF;
   localparam logic [TEMP_W-1:0]       SAT_NEG  = 16'h8000;

   localparam logic [CNT_W-1:0] CRC_LAST = 5'd6;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

   localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
   localparam logic [ST_W-1:0] ST_CRC  = 3'd1;
   localparam logic [ST_W-1:0] ST_SUM  = 3'd2;
   localparam logic [ST_W-1:0] ST_ABS  = 3'd3;
   localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
   localparam logic [ST_W-1:0] ST_FIN  = 3'd5;

   function automatic logic [BYTE_W-1:0] crc_bit_step(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] shifted;
      shifted = v >> 1;
      return v[0] ? (shifted ^ CRC_POLY) : shifted;
   endfunction

endpackage

[design/temp_scratchpad_decoder_unit.sv]
// Scratchpad decoder for a 1-wire temperature sensor: CRC-8 check and temperature.
// Depends on tsd_pkg for widths, constants, state codes and the CRC bit step.
// Bytes 0 to 7 go through the CRC-8 one bit per cycle while req_ready is low.
// The ninth byte passes through the sum, absolute, divide and finish states, with a
// restoring divide by 20 that produces one quotient bit per cycle over 23 bits.
// Reset is synchronous and clears the byte counter, the CRC and the result valid.
module temp_scratchpad_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tsd_pkg::BYTE_W-1:0]         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_crc_ok,
   output logic signed [tsd_pkg::TEMP_W-1:0]  rsp_temperature,
   output logic signed [tsd_pkg::TEMP_W-1:0]  rsp_raw_reading,
   output logic [tsd_pkg::BYTE_W-1:0]         rsp_computed_crc
);
   import tsd_pkg::*;

   logic [ST_W-1:0]          state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [BYTE_W-1:0]        running_crc_ff, running_crc_in;
   logic [BYTE_W-1:0]        reading_low_ff, reading_low_in;
   logic [BYTE_W-1:0]        reading_high_ff, reading_high_in;
   logic [BYTE_W-1:0]        count_rem_ff, count_rem_in;
   logic [BYTE_W-1:0]        shift_ff, shift_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     ok_ff, ok_in;
   logic [BYTE_W-1:0]        crc_hold_ff, crc_hold_in;
   logic signed [NUM_W-1:0]  prod_ff, prod_in;
   logic signed [NUM_W-1:0]  frac_ff, frac_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         dvd_ff, dvd_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic [TEMP_W-1:0]        rsp_temp_ff, rsp_temp_in;
   logic [TEMP_W-1:0]        rsp_raw_ff, rsp_raw_in;
   logic [BYTE_W-1:0]        rsp_crc_ff, rsp_crc_in;

   logic signed [NUM_W-1:0]  tread_ext;
   logic signed [9:0]        cnt_diff;
   logic signed [TEMP_W-1:0] frac_prod;
   logic signed [TEMP_W-1:0] frac_prod_neg;
   logic signed [TEMP_W-1:0] frac_val;
   logic signed [NUM_W-1:0]  num_neg;
   logic [REM_W:0]           trial;
   logic                     qbit;
   logic [TEMP_W-1:0]        sat_val;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_crc_ok       = rsp_ok_ff;
   assign rsp_temperature  = rsp_temp_ff;
   assign rsp_raw_reading  = rsp_raw_ff;
   assign rsp_computed_crc = rsp_crc_ff;

   always_comb begin
      tread_ext     = NUM_W'($signed({reading_high_ff, reading_low_ff}));
      cnt_diff      = BIAS - $signed({2'b00, count_rem_ff});
      frac_prod     = (TEMP_W'(cnt_diff) <<< 6) + (TEMP_W'(cnt_diff) <<< 5)
                      + (TEMP_W'(cnt_diff) <<< 2);
      frac_prod_neg = -frac_prod;
      frac_val      = frac_prod[TEMP_W-1] ? -$signed(frac_prod_neg >> 4) : (frac_prod >>> 4);
      num_neg       = -num_ff;
      trial         = {rem_ff, dvd_ff[MAG_W-1]};
      qbit          = (trial >= DIVISOR);
      if (neg_ff) begin
         sat_val = (dvd_ff > NEG_MAX) ? SAT_NEG : (-dvd_ff[TEMP_W-1:0]);
      end else begin
         sat_val = (dvd_ff > POS_MAX) ? SAT_POS : dvd_ff[TEMP_W-1:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      running_crc_in  = running_crc_ff;
      reading_low_in  = reading_low_ff;
      reading_high_in = reading_high_ff;
      count_rem_in    = count_rem_ff;
      shift_in        = shift_ff;
      cnt_in          = cnt_ff;
      ok_in           = ok_ff;
      crc_hold_in     = crc_hold_ff;
      prod_in         = prod_ff;
      frac_in         = frac_ff;
      num_in          = num_ff;
      neg_in          = neg_ff;
      dvd_in          = dvd_ff;
      rem_in          = rem_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_ok_in       = rsp_ok_ff;
      rsp_temp_in     = rsp_temp_ff;
      rsp_raw_in      = rsp_raw_ff;
      rsp_crc_in      = rsp_crc_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (idx_ff < SCRATCH_LAST) begin
                  shift_in = crc_bit_step(running_crc_ff ^ req_data_byte);
                  cnt_in   = '0;
                  idx_in   = idx_ff + 1'b1;
                  if (idx_ff == IDX_READ_LO) begin
                     reading_low_in = req_data_byte;
                  end else if (idx_ff == IDX_READ_HI) begin
                     reading_high_in = req_data_byte;
                  end else if (idx_ff == IDX_COUNT) begin
                     count_rem_in = req_data_byte;
                  end
                  state_in = ST_CRC;
               end else begin
                  ok_in          = (req_data_byte == running_crc_ff);
                  crc_hold_in    = running_crc_ff;
                  prod_in        = (tread_ext <<< 6) + (tread_ext <<< 5) + (tread_ext <<< 2);
                  frac_in        = NUM_W'(frac_val);
                  idx_in         = '0;
                  running_crc_in = '0;
                  state_in       = ST_SUM;
               end
            end
         end
         ST_CRC: begin
            shift_in = crc_bit_step(shift_ff);
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CRC_LAST) begin
               running_crc_in = crc_bit_step(shift_ff);
               state_in       = ST_IDLE;
            end
         end
         ST_SUM: begin
            num_in   = prod_ff + frac_ff - OFFSET;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = num_ff[NUM_W-1];
            dvd_in   = num_ff[NUM_W-1] ? num_neg[MAG_W-1:0] : num_ff[MAG_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? REM_W'(trial - DIVISOR) : trial[REM_W-1:0];
            dvd_in = {dvd_ff[MAG_W-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_temp_in  = ok_ff ? sat_val : '0;
               rsp_raw_in   = ok_ff ? {reading_high_ff, reading_low_ff} : '0;
               rsp_crc_in   = crc_hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= '0;
         running_crc_ff  <= '0;
         reading_low_ff  <= '0;
         reading_high_ff <= '0;
         count_rem_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         running_crc_ff  <= running_crc_in;
         reading_low_ff  <= reading_low_in;
         reading_high_ff <= reading_high_in;
         count_rem_ff    <= count_rem_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      cnt_ff      <= cnt_in;
      ok_ff       <= ok_in;
      crc_hold_ff <= crc_hold_in;
      prod_ff     <= prod_in;
      frac_ff     <= frac_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_crc_ff  <= rsp_crc_in;
   end

endmodule

[tb/sv/testbench.sv]
// Testbench for temp_scratchpad_decoder_unit: sends nine-byte scratchpads and checks each
// decoded result against a predictor kept in step with the accepted bytes.
// Depends on tsd_pkg and temp_scratchpad_decoder_unit.
module testbench;
   import tsd_pkg::*;

   localparam int PAD_LEN     = 9;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 60;
   localparam int RANDOM_PADS = 203;

   typedef struct {
      logic                     crc_ok;
      logic signed [TEMP_W-1:0] temperature;
      logic signed [TEMP_W-1:0] raw_reading;
      logic [BYTE_W-1:0]        computed_crc;
   } reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [BYTE_W-1:0]        req_data_byte = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_crc_ok;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic signed [TEMP_W-1:0] rsp_raw_reading;
   logic [BYTE_W-1:0]        rsp_computed_crc;

   reading_type       pending_readings[$];
   logic [IDX_W-1:0]  pad_pos = '0;
   logic [BYTE_W-1:0] crc_acc = '0;
   logic [BYTE_W-1:0] read_lo = '0;
   logic [BYTE_W-1:0] read_hi = '0;
   logic [BYTE_W-1:0] count_rem = '0;

   int  cycle_count = 0;
   int  failures = 0;
   int  bytes_sent = 0;
   int  results_checked = 0;
   int  bad_crc_seen = 0;
   int  saturated_seen = 0;
   bit  no_idle = 1'b0;

   temp_scratchpad_decoder_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_temperature  (rsp_temperature),
      .rsp_raw_reading  (rsp_raw_reading),
      .rsp_computed_crc (rsp_computed_crc)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] v;
      v = crc ^ data;
      repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      return v;
   endfunction

   // Advances the decoder state by one accepted byte and queues the result
   // that the ninth byte produces.
   task automatic decode_scratch_byte(input logic [BYTE_W-1:0] b);
      reading_type exp_r;
      int          reading;
      int          frac;
      int          t;
      if (pad_pos < SCRATCH_LAST) begin
         crc_acc = crc8_next(crc_acc, b);
         if (pad_pos == IDX_READ_LO) read_lo = b;
         else if (pad_pos == IDX_READ_HI) read_hi = b;
         else if (pad_pos == IDX_COUNT) count_rem = b;
         pad_pos = pad_pos + 1'b1;
      end else begin
         reading = int'($signed({read_hi, read_lo}));
         frac = ((16 - int'(count_rem)) * 100) / 16;
         t = (reading * 100 - 25 + frac) / 20;
         if (t > 32767) t = 32767;
         else if (t < -32768) t = -32768;
         exp_r.crc_ok       = (b == crc_acc);
         exp_r.temperature  = exp_r.crc_ok ? TEMP_W'(t) : '0;
         exp_r.raw_reading  = exp_r.crc_ok ? {read_hi, read_lo} : '0;
         exp_r.computed_crc = crc_acc;
         pending_readings.push_back(exp_r);
         pad_pos = '0;
         crc_acc = '0;
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      decode_scratch_byte(b);
   endtask

   task automatic send_scratchpad(input logic [TEMP_W-1:0] reading,
                                  input logic [BYTE_W-1:0] count, input bit corrupt);
      logic [BYTE_W-1:0] pad[PAD_LEN];
      logic [BYTE_W-1:0] crc;
      int                i;
      crc = '0;
      for (i = 0; i < PAD_LEN - 1; i++) begin
         pad[i] = BYTE_W'($urandom_range(0, 255));
         if (i == IDX_READ_LO) pad[i] = reading[7:0];
         if (i == IDX_READ_HI) pad[i] = reading[15:8];
         if (i == IDX_COUNT) pad[i] = count;
         crc = crc8_next(crc, pad[i]);
      end
      pad[PAD_LEN-1] = corrupt ? crc ^ BYTE_W'($urandom_range(1, 255)) : crc;
      for (i = 0; i < PAD_LEN; i++) send_byte(pad[i], pick_gap());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (no_idle || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            stall = pick_gap();
            rsp_ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $error("Result arrived with no request outstanding.");
            failures++;
         end else begin
            exp_r = pending_readings.pop_front();
            results_checked++;
            if (!exp_r.crc_ok) bad_crc_seen++;
            if (exp_r.crc_ok && (exp_r.temperature == 16'sh7FFF ||
                                 exp_r.temperature == -16'sh8000)) saturated_seen++;
            if (rsp_crc_ok !== exp_r.crc_ok) begin
               $error("crc_ok: expected %0d, actual %0d", exp_r.crc_ok, rsp_crc_ok);
               failures++;
            end
            if (rsp_temperature !== exp_r.temperature) begin
               $error("temperature: expected %0d, actual %0d",
                      exp_r.temperature, rsp_temperature);
               failures++;
            end
            if (rsp_raw_reading !== exp_r.raw_reading) begin
               $error("raw_reading: expected %0d, actual %0d",
                      exp_r.raw_reading, rsp_raw_reading);
               failures++;
            end
            if (rsp_computed_crc !== exp_r.computed_crc) begin
               $error("computed_crc: expected 0x%02h, actual 0x%02h",
                      exp_r.computed_crc, rsp_computed_crc);
               failures++;
            end
         end
      end
   end

   task automatic test_extremes();
      send_scratchpad(16'h7FFF, 8'd0, 1'b0);
      send_scratchpad(16'h8000, 8'd255, 1'b0);
   endtask

   task automatic test_bad_crc();
      send_scratchpad(16'h0032, 8'd16, 1'b1);
   endtask

   task automatic test_drain_pause();
      wait_drained();
      send_scratchpad(16'h0000, 8'd12, 1'b0);
   endtask

   task automatic test_random_scratchpads();
      logic [TEMP_W-1:0] reading;
      logic [BYTE_W-1:0] count;
      int                n;
      int                r;
      int                v;
      for (n = 0; n < RANDOM_PADS; n++) begin
         no_idle = ((n / 40) % 3) == 2;
         r = $urandom_range(0, 9);
         if (r < 3) begin
            v = $urandom_range(0, 360);
            reading = TEMP_W'(v - 110);
         end else if (r < 4) begin
            v = 6553 + $urandom_range(0, 7) - 3;
            reading = $urandom_range(0, 1) ? TEMP_W'(v) : TEMP_W'(-v);
         end else begin
            reading = TEMP_W'($urandom_range(0, 65535));
         end
         count = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 16))
                                      : BYTE_W'($urandom_range(0, 255));
         if ($urandom_range(0, 39) == 0) wait_drained();
         send_scratchpad(reading, count, $urandom_range(0, 99) < 15);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_bad_crc();
      test_drain_pause();
      test_random_scratchpads();
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d scratchpad bytes and checked %0d decoded readings.",
               bytes_sent, results_checked);
      $display("Of those, %0d had a failed CRC and %0d had a saturated temperature.",
               bad_crc_seen, saturated_seen);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
design/tsd_pkg.sv
design/temp_scratchpad_decoder_unit.sv
tb/sv/testbench.sv
